FILE: rtl/lse_pkg.sv
// shared types and constants for the load, sort and emit engine
// no dependencies
package lse_pkg;

    localparam int CAPACITY = 64;
    localparam int VALUE_W  = 32;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int COUNT_W  = ADDR_W + 1;

    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      last_in;
    } lse_in_beat_t;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sorted_value;
        logic                      last_out;
        logic                      overflow;
    } lse_out_beat_t;

endpackage

FILE: rtl/load_sort_emit_engine_unit.sv
// load, sort and emit engine: stores a stream of signed values, bubble-sorts it, emits it
// depends on lse_pkg; holds the element store as an internal memory with a registered read
//
// Data beats are stored one per cycle in arrival order into a 64-entry store; beats that
// arrive at a full store are dropped and flag the run as overflowed. The beat marked
// last_in closes the run: the block then stalls its input and sorts the n stored elements
// in place with n-1 bubble passes on the single read and single write port of the store (one
// compare per cycle against a carried running maximum). It then emits the n elements in
// ascending order, each read from the store and held as a result beat until it is taken,
// marking the final beat with last_out; equal values keep their arrival order. After the
// final result beat is taken, the next run can start loading.
module load_sort_emit_engine_unit
    import lse_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          data_valid,
    output logic          data_stall,
    input  lse_in_beat_t  data,
    output logic          result_valid,
    input  logic          result_stall,
    output lse_out_beat_t result
);

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_RD0   = 7'b0000010,
        ST_RD1   = 7'b0000100,
        ST_CMP   = 7'b0001000,
        ST_WEND  = 7'b0010000,
        ST_EMRD  = 7'b0100000,
        ST_EMOUT = 7'b1000000
    } state_t;

    logic signed [VALUE_W-1:0] mem [CAPACITY];

    state_t                    state_reg, state_next;
    logic [COUNT_W-1:0]        count_reg, count_next;
    logic                      dropped_reg, dropped_next;
    logic [ADDR_W-1:0]         pos_reg, pos_next;
    logic [ADDR_W-1:0]         pass_reg, pass_next;
    logic signed [VALUE_W-1:0] carry_reg, carry_next;
    logic                      result_valid_reg, result_valid_next;
    lse_out_beat_t             result_reg, result_next;
    logic signed [VALUE_W-1:0] rd_data_reg;

    logic                      mem_we;
    logic [ADDR_W-1:0]         mem_waddr;
    logic [ADDR_W-1:0]         mem_raddr;
    logic signed [VALUE_W-1:0] mem_wdata;

    logic [ADDR_W-1:0]         last_idx;
    logic                      data_take;
    logic                      full;
    logic [COUNT_W-1:0]        count_inc;

    assign last_idx   = ADDR_W'(count_reg - COUNT_W'(1));
    assign data_stall = (state_reg != ST_LOAD);
    assign data_take  = data_valid && !data_stall;
    assign full       = (count_reg == COUNT_W'(CAPACITY));
    assign count_inc  = count_reg + COUNT_W'(1);

    always_comb
    begin
        state_next        = state_reg;
        count_next        = count_reg;
        dropped_next      = dropped_reg;
        pos_next          = pos_reg;
        pass_next         = pass_reg;
        carry_next        = carry_reg;
        result_valid_next = result_valid_reg;
        result_next       = result_reg;
        mem_we            = 1'b0;
        mem_waddr         = count_reg[ADDR_W-1:0];
        mem_wdata         = data.value;
        mem_raddr         = pos_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (data_take)
                begin
                    if (!full)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_inc;
                    end
                    else
                    begin
                        dropped_next = 1'b1;
                    end
                    if (data.last_in)
                    begin
                        pass_next = '0;
                        pos_next  = '0;
                        if ((full ? count_reg : count_inc) >= COUNT_W'(2))
                            state_next = ST_RD0;
                        else
                            state_next = ST_EMRD;
                    end
                end
            end
            ST_RD0:
            begin
                mem_raddr  = '0;
                pos_next   = ADDR_W'(1);
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                carry_next = rd_data_reg;
                mem_raddr  = pos_reg;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = pos_reg - ADDR_W'(1);
                if (carry_reg > rd_data_reg)
                begin
                    mem_wdata = rd_data_reg;
                end
                else
                begin
                    mem_wdata  = carry_reg;
                    carry_next = rd_data_reg;
                end
                mem_raddr = pos_reg + ADDR_W'(1);
                if (pos_reg == last_idx)
                    state_next = ST_WEND;
                else
                    pos_next = pos_reg + ADDR_W'(1);
            end
            ST_WEND:
            begin
                mem_we    = 1'b1;
                mem_waddr = last_idx;
                mem_wdata = carry_reg;
                pass_next = pass_reg + ADDR_W'(1);
                if (pass_next == last_idx)
                begin
                    pos_next   = '0;
                    state_next = ST_EMRD;
                end
                else
                begin
                    state_next = ST_RD0;
                end
            end
            ST_EMRD:
            begin
                mem_raddr  = pos_reg;
                state_next = ST_EMOUT;
            end
            ST_EMOUT:
            begin
                if (!result_valid_reg)
                begin
                    result_valid_next        = 1'b1;
                    result_next.sorted_value = rd_data_reg;
                    result_next.last_out     = (pos_reg == last_idx);
                    result_next.overflow     = dropped_reg;
                end
                else if (!result_stall)
                begin
                    result_valid_next = 1'b0;
                    if (result_reg.last_out)
                    begin
                        count_next   = '0;
                        dropped_next = 1'b0;
                        state_next   = ST_LOAD;
                    end
                    else
                    begin
                        pos_next   = pos_reg + ADDR_W'(1);
                        state_next = ST_EMRD;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            count_reg        <= '0;
            dropped_reg      <= 1'b0;
            pos_reg          <= '0;
            pass_reg         <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            dropped_reg      <= dropped_next;
            pos_reg          <= pos_next;
            pass_reg         <= pass_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        carry_reg  <= carry_next;
        result_reg <= result_next;
    end

    // element store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_valid_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> state_reg == ST_EMOUT)
        else $error("result beat outside emit");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("element count beyond capacity");
    a_run_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_stall && result.last_out) |=>
            (count_reg == '0 && !dropped_reg && state_reg == ST_LOAD))
        else $error("run not cleared after final beat");
    a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CMP) |-> (pos_reg != '0 && pos_reg <= last_idx))
        else $error("compare position out of range");
`endif

endmodule
